[rtl/spvs_pkg.sv]
package spvs_pkg;

   localparam int WORD_W = 32;
   localparam int CNT_W = 5;
   localparam int EXP_W = 4;
   localparam int NUM_COEF = 4;
   localparam int CSR_IDX_W = 3;

   localparam int DEF_MAX_TERMS = 4;
   localparam int DEF_MAX_EXPONENT = 15;
   localparam int DEF_FRACTION_BITS = 16;

   localparam logic [CSR_IDX_W-1:0] REG_COEF_ZERO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_ONE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_TWO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_THREE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EXPONENT_PACK = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TERM_COUNT = 3'd5;

   typedef struct packed {
      logic                     start;
      logic                     scale;
      logic signed [WORD_W-1:0] a;
      logic signed [WORD_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [WORD_W-1:0] prod;
   } mul_rsp_type;

endpackage

[rtl/sparse_polynomial_value_slope_core.sv]
// Work: per active, non-replaced term with exponent e, (e + 1 + 2*(e != 0)) serial
// multiplies; a replaced term is skipped without a multiply. The argument is then
// finished and the result presented.
// Throughput: one beat at a time, bound by the single bit-serial 32x32 multiplier.
// Reset: synchronous, active high; clears control state and all config registers to 0.
module sparse_polynomial_value_slope_core
   import spvs_pkg::*;
#(
   parameter int MAX_TERMS = DEF_MAX_TERMS,
   parameter int MAX_EXPONENT = DEF_MAX_EXPONENT,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WORD_W-1:0] req_arg_x,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_poly_value,
   output logic signed [WORD_W-1:0] rsp_poly_slope,
   output logic                     rsp_saturated,
   input  logic                     csr_wen,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [WORD_W-1:0]        csr_wdata
);

   localparam int SUM_W = WORD_W + 3;
   localparam logic signed [WORD_W-1:0] ONE = WORD_W'(64'sd1 <<< FRACTION_BITS);
   localparam logic [2:0] TERMS_CAP = 3'(MAX_TERMS);
   localparam logic [EXP_W-1:0] EXP_CAP = EXP_W'(MAX_EXPONENT);
   localparam logic signed [SUM_W-1:0] SMAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SMIN = SUM_W'(-64'sd2147483648);

   typedef enum logic [1:0] {S_IDLE, S_TERM, S_MUL} state_type;
   typedef enum logic [1:0] {OP_POW, OP_VAL, OP_SLP, OP_SCL} op_type;

   state_type state_ff;
   op_type    op_ff;

   // config registers
   logic signed [WORD_W-1:0] coef_ff [NUM_COEF];
   logic [4*EXP_W-1:0]       exp_pack_ff;
   logic [2:0]               term_count_ff;

   // working registers
   logic signed [WORD_W-1:0] x_ff, pw_ff, pprev_ff;
   logic signed [SUM_W-1:0]  vsum_ff, ssum_ff;
   logic [2:0]               k_ff;
   logic [EXP_W-1:0]         i_ff;
   logic                     sat_ff;
   mul_req_type              mreq_ff;
   mul_rsp_type              mrsp;

   logic                     rsp_valid_ff, rsp_sat_ff;
   logic signed [WORD_W-1:0] rsp_value_ff, rsp_slope_ff;

   logic [2:0]               n_act;
   logic [EXP_W-1:0]         e_cur;
   logic [EXP_W-1:0]         i_next;
   logic                     replaced;
   logic                     v_hi, v_lo, s_hi, s_lo;
   logic signed [WORD_W-1:0] coef_cur;

   function automatic logic [EXP_W-1:0] term_exp(input logic [4*EXP_W-1:0] pack,
                                                 input logic [1:0] idx);
      logic [EXP_W-1:0] e;
      e = pack[EXP_W*idx +: EXP_W];
      return (e > EXP_CAP) ? EXP_CAP : e;
   endfunction

   // active term count, current exponent and coefficient, duplicate check against later terms, sum range flags
   always_comb begin
      n_act = (term_count_ff > TERMS_CAP) ? TERMS_CAP : term_count_ff;
      e_cur = term_exp(exp_pack_ff, k_ff[1:0]);
      coef_cur = coef_ff[k_ff[1:0]];
      i_next = i_ff + 1'b1;
      replaced = 1'b0;
      for (int j = 0; j < NUM_COEF; j++) begin
         if (3'(j) > k_ff && 3'(j) < n_act && term_exp(exp_pack_ff, 2'(j)) == e_cur) begin
            replaced = 1'b1;
         end
      end
      v_hi = vsum_ff > SMAX;
      v_lo = vsum_ff < SMIN;
      s_hi = ssum_ff > SMAX;
      s_lo = ssum_ff < SMIN;
   end

   spvs_mul #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_mul (
      .clock(clock),
      .reset(reset),
      .req  (mreq_ff),
      .rsp  (mrsp)
   );

   // config writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_COEF; c++) begin
            coef_ff[c] <= '0;
         end
         exp_pack_ff <= '0;
         term_count_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_COEF_ZERO, REG_COEF_ONE, REG_COEF_TWO, REG_COEF_THREE: begin
               coef_ff[csr_index[1:0]] <= csr_wdata;
            end
            REG_EXPONENT_PACK: exp_pack_ff <= csr_wdata[4*EXP_W-1:0];
            REG_TERM_COUNT: term_count_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // sequencer: walk terms, issue multiplies, accumulate, present result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_POW;
         rsp_valid_ff <= 1'b0;
         mreq_ff.start <= 1'b0;
         k_ff <= '0;
         i_ff <= '0;
      end else begin
         mreq_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff <= req_arg_x;
                  k_ff <= '0;
                  vsum_ff <= '0;
                  ssum_ff <= '0;
                  sat_ff <= 1'b0;
                  state_ff <= S_TERM;
               end
            end
            S_TERM: begin
               if (k_ff >= n_act) begin
                  // hold until the output register is free
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_value_ff <= v_hi ? 32'sh7fffffff :
                                     v_lo ? 32'sh80000000 : vsum_ff[WORD_W-1:0];
                     rsp_slope_ff <= s_hi ? 32'sh7fffffff :
                                     s_lo ? 32'sh80000000 : ssum_ff[WORD_W-1:0];
                     rsp_sat_ff <= sat_ff | v_hi | v_lo | s_hi | s_lo;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else if (replaced) begin
                  k_ff <= k_ff + 1'b1;
               end else begin
                  pw_ff <= ONE;
                  pprev_ff <= ONE;
                  i_ff <= '0;
                  mreq_ff.start <= 1'b1;
                  mreq_ff.scale <= 1'b0;
                  if (e_cur != '0) begin
                     op_ff <= OP_POW;
                     mreq_ff.a <= ONE;
                     mreq_ff.b <= x_ff;
                  end else begin
                     op_ff <= OP_VAL;
                     mreq_ff.a <= coef_cur;
                     mreq_ff.b <= ONE;
                  end
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (mrsp.done) begin
                  sat_ff <= sat_ff | mrsp.sat;
                  case (op_ff)
                     OP_POW: begin
                        pprev_ff <= pw_ff;
                        pw_ff <= mrsp.prod;
                        i_ff <= i_next;
                        mreq_ff.start <= 1'b1;
                        mreq_ff.scale <= 1'b0;
                        if (i_next == e_cur) begin
                           op_ff <= OP_VAL;
                           mreq_ff.a <= coef_cur;
                           mreq_ff.b <= mrsp.prod;
                        end else begin
                           mreq_ff.a <= mrsp.prod;
                           mreq_ff.b <= x_ff;
                        end
                     end
                     OP_VAL: begin
                        vsum_ff <= vsum_ff + SUM_W'(mrsp.prod);
                        if (e_cur != '0) begin
                           op_ff <= OP_SLP;
                           mreq_ff.start <= 1'b1;
                           mreq_ff.scale <= 1'b0;
                           mreq_ff.a <= coef_cur;
                           mreq_ff.b <= pprev_ff;
                        end else begin
                           k_ff <= k_ff + 1'b1;
                           state_ff <= S_TERM;
                        end
                     end
                     OP_SLP: begin
                        // scale by the integer exponent, no fraction shift
                        op_ff <= OP_SCL;
                        mreq_ff.start <= 1'b1;
                        mreq_ff.scale <= 1'b1;
                        mreq_ff.a <= mrsp.prod;
                        mreq_ff.b <= WORD_W'(e_cur);
                     end
                     OP_SCL: begin
                        ssum_ff <= ssum_ff + SUM_W'(mrsp.prod);
                        k_ff <= k_ff + 1'b1;
                        state_ff <= S_TERM;
                     end
                     default: ;
                  endcase
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_poly_value = rsp_value_ff;
   assign rsp_poly_slope = rsp_slope_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= TERMS_CAP) else $error("term index out of range");
   a_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> state_ff == S_MUL) else $error("multiply done outside wait");
   a_pow_range: assert property (@(posedge clock) disable iff (reset)
      i_ff <= EXP_CAP) else $error("power count out of range");
   a_start_source: assert property (@(posedge clock) disable iff (reset)
      mreq_ff.start |-> $past(state_ff) == S_TERM || $past(state_ff) == S_MUL)
      else $error("multiply issued from idle");

endmodule

[rtl/spvs_mul.sv]
module spvs_mul
   import spvs_pkg::*;
#(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam logic signed [2*WORD_W-1:0] RND = 64'sd1 <<< (FRACTION_BITS - 1);
   localparam logic signed [2*WORD_W-1:0] MAXV = 64'sd2147483647;
   localparam logic signed [2*WORD_W-1:0] MINV = -64'sd2147483648;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

   logic                     busy_ff, fin_ff, scale_ff, done_ff, sat_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [WORD_W:0]   hi_ff;
   logic [WORD_W-1:0]        lo_ff;
   logic signed [WORD_W-1:0] a_ff, prod_ff;

   logic signed [WORD_W+1:0]   addend, sum_in;
   logic signed [2*WORD_W-1:0] full, rounded, pick;

   // one multiplier bit per cycle; the sign bit carries negative weight; the product is rounded unless scaling
   always_comb begin
      if (!lo_ff[0]) begin
         addend = '0;
      end else if (cnt_ff == LAST) begin
         addend = -(WORD_W+2)'(a_ff);
      end else begin
         addend = (WORD_W+2)'(a_ff);
      end
      sum_in = (WORD_W+2)'(hi_ff) + addend;
      full = {hi_ff[WORD_W-1:0], lo_ff};
      rounded = (full + RND) >>> FRACTION_BITS;
      pick = scale_ff ? full : rounded;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            hi_ff <= '0;
            lo_ff <= req.b;
            a_ff <= req.a;
            scale_ff <= req.scale;
         end else if (busy_ff) begin
            hi_ff <= sum_in[WORD_W+1:1];
            lo_ff <= {sum_in[0], lo_ff[WORD_W-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff <= 1'b0;
            done_ff <= 1'b1;
            if (pick > MAXV) begin
               prod_ff <= 32'sh7fffffff;
               sat_ff <= 1'b1;
            end else if (pick < MINV) begin
               prod_ff <= 32'sh80000000;
               sat_ff <= 1'b1;
            end else begin
               prod_ff <= pick[WORD_W-1:0];
               sat_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.sat = sat_ff;
   assign rsp.prod = prod_ff;

   a_fin_once: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !busy_ff) else $error("finish overlaps iteration");
   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(fin_ff)) else $error("done without finish");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff && !fin_ff) else $error("start while busy");

endmodule

[test/tb_sparse_polynomial_value_slope_core.sv]
`timescale 1ns / 100ps

module tb_sparse_polynomial_value_slope_core;
   import spvs_pkg::*;

   localparam int FRAC = DEF_FRACTION_BITS;
   localparam longint CYCLE_LIMIT = 20_000_000;
   // No register lives at this index; a write to it must leave the terms alone.
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd6;
   localparam logic signed [WORD_W-1:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [WORD_W-1:0] value;
      logic signed [WORD_W-1:0] slope;
      logic                     sat;
   } poly_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [WORD_W-1:0] req_arg_x;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [WORD_W-1:0] rsp_poly_value;
   logic signed [WORD_W-1:0] rsp_poly_slope;
   logic                     rsp_saturated;
   logic                     csr_wen;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [WORD_W-1:0]        csr_wdata;

   // Shadow copy of the term registers.
   logic signed [WORD_W-1:0] coef_q[NUM_COEF];
   logic [15:0]              exp_pack_q;
   logic [2:0]               term_count_q;

   poly_result_type pending_poly[$];
   int           fail_count = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           hold_off_cycles = 0;
   longint       cycle_count = 0;

   sparse_polynomial_value_slope_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung block ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** sparse_polynomial_value_slope_core: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor: fixed-point power series, rounded and clamped per product
   // ---------------------------------------------------------------------
   function automatic logic signed [WORD_W-1:0] clamp_word(input longint v, inout logic sat);
      if (v > longint'(Q_MAX)) begin
         sat = 1'b1;
         return Q_MAX;
      end
      if (v < longint'(Q_MIN)) begin
         sat = 1'b1;
         return Q_MIN;
      end
      return v[WORD_W-1:0];
   endfunction

   // Round to nearest with ties toward plus infinity: add half, then floor.
   function automatic logic signed [WORD_W-1:0] fx_mul(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b,
                                                       inout logic sat);
      longint p;
      p = longint'(a) * longint'(b);
      p = (p + (longint'(1) << (FRAC - 1))) >>> FRAC;
      return clamp_word(p, sat);
   endfunction

   function automatic int term_exponent(input int k);
      int e;
      e = int'(exp_pack_q[4*k +: EXP_W]);
      return (e > DEF_MAX_EXPONENT) ? DEF_MAX_EXPONENT : e;
   endfunction

   function automatic poly_result_type eval_poly(input logic signed [WORD_W-1:0] x);
      poly_result_type r;
      logic sat;
      longint vsum, ssum;
      int n, e;
      bit shadowed;
      logic signed [WORD_W-1:0] pw, pprev, t;
      sat = 1'b0;
      vsum = 0;
      ssum = 0;
      n = (term_count_q > DEF_MAX_TERMS) ? DEF_MAX_TERMS : int'(term_count_q);
      for (int k = 0; k < n; k++) begin
         e = term_exponent(k);
         shadowed = 1'b0;
         // A later term with the same exponent replaces this one.
         for (int j = k + 1; j < n; j++)
            if (term_exponent(j) == e) shadowed = 1'b1;
         if (!shadowed) begin
            pw = Q_ONE;
            pprev = Q_ONE;
            for (int i = 0; i < e; i++) begin
               pprev = pw;
               pw = fx_mul(pw, x, sat);
            end
            vsum += longint'(fx_mul(coef_q[k], pw, sat));
            if (e != 0) begin
               t = fx_mul(coef_q[k], pprev, sat);
               ssum += longint'(clamp_word(longint'(t) * e, sat));
            end
         end
      end
      r.value = clamp_word(vsum, sat);
      r.slope = clamp_word(ssum, sat);
      r.sat = sat;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: ready pattern and checker
   // ---------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         // A long hold-off lets the block fill up and back-pressure the sender.
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Sample mid-cycle so the beat taken at the next edge is stable.
   initial begin
      poly_result_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_poly.size() == 0) begin
               $display("%0t: result beat with nothing pending: value %h slope %h sat %b",
                        $time, rsp_poly_value, rsp_poly_slope, rsp_saturated);
               fail_count++;
            end else begin
               want = pending_poly.pop_front();
               if (rsp_poly_value !== want.value) begin
                  $display("%0t: poly_value expected %h actual %h",
                           $time, want.value, rsp_poly_value);
                  fail_count++;
               end
               if (rsp_poly_slope !== want.slope) begin
                  $display("%0t: poly_slope expected %h actual %h",
                           $time, want.slope, rsp_poly_slope);
                  fail_count++;
               end
               if (rsp_saturated !== want.sat) begin
                  $display("%0t: saturated expected %b actual %b",
                           $time, want.sat, rsp_saturated);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared drivers
   // ---------------------------------------------------------------------
   // Send one argument beat. Called at a rising edge; leaves valid high so a
   // back-to-back beat needs no drop in between.
   task automatic send_arg(input logic signed [WORD_W-1:0] x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_arg_x <= x;
      do @(negedge clock); while (!req_ready);
      pending_poly.push_back(eval_poly(x));
      @(posedge clock);
   endtask

   // Drop valid, wait for every pending result, then let the block settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_poly.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx < NUM_COEF)
         coef_q[idx] = data;
      else if (idx == REG_EXPONENT_PACK)
         exp_pack_q = data[15:0];
      else if (idx == REG_TERM_COUNT)
         term_count_q = data[2:0];
   endtask

   // Load all term registers back to back; only call when drained.
   task automatic load_terms(input logic signed [WORD_W-1:0] c0, c1, c2, c3,
                             input logic [15:0] pack, input logic [2:0] count);
      csr_write(REG_COEF_ZERO, c0);
      csr_write(REG_COEF_ONE, c1);
      csr_write(REG_COEF_TWO, c2);
      csr_write(REG_COEF_THREE, c3);
      csr_write(REG_EXPONENT_PACK, {16'h0, pack});
      csr_write(REG_TERM_COUNT, {29'h0, count});
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] rand_coef;
      case ($urandom_range(3))
         0: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         1: return $urandom;
         2: case ($urandom_range(3))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return Q_ONE;
               default: return -Q_ONE;
            endcase
         default: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
      endcase
   endfunction

   function automatic logic signed [WORD_W-1:0] rand_arg;
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      if (pick < 90) return $urandom;
      case ($urandom_range(5))
         0: return 0;
         1: return Q_ONE;
         2: return -Q_ONE;
         3: return Q_MAX;
         4: return Q_MIN;
         default: return 1;
      endcase
   endfunction

   // Random terms: mostly low exponents to keep the serial multiplier quick.
   task automatic load_random_terms;
      logic [15:0] pack;
      logic [2:0]  count;
      for (int k = 0; k < NUM_COEF; k++)
         pack[4*k +: EXP_W] = ($urandom_range(9) == 0) ? EXP_W'($urandom_range(15))
                                                        : EXP_W'($urandom_range(3));
      count = ($urandom_range(6) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
      load_terms(rand_coef(), rand_coef(), rand_coef(), rand_coef(), pack, count);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Straight out of reset there are no active terms.
   task automatic test_reset_terms;
      send_arg(32'sh0001_2345);
      send_arg(Q_MIN);
      drain();
   endtask

   task automatic test_directed;
      // f = 2x^2 + 3x + 1
      load_terms(2 * Q_ONE, 3 * Q_ONE, Q_ONE, 0, 16'h0012, 3'd3);
      // Unmapped index: must not disturb the terms just loaded.
      csr_write(REG_UNMAPPED, 32'hFFFF_FFFF);
      csr_wen <= 1'b0;
      @(posedge clock);
      send_arg(0);
      send_arg(Q_ONE);
      send_arg(-Q_ONE);
      send_arg(32'sh0002_8000);
      send_arg(Q_MAX);
      send_arg(Q_MIN);
      send_arg(1);
      drain();
      // Duplicate exponent: the last x^2 term wins.
      load_terms(5 * Q_ONE, -7 * Q_ONE, 32'sh0000_8000, -3 * Q_ONE, 16'h2122, 3'd4);
      send_arg(32'sh0001_8000);
      send_arg(-3 * Q_ONE);
      drain();
      // Oversized term count, top exponent and extreme coefficients.
      load_terms(Q_MAX, Q_MIN, 1, -1, 16'h370F, 3'd7);
      send_arg(32'sh0001_0800);
      send_arg(2 * Q_ONE);
      send_arg(-32'sh0000_8000);
      send_arg(-1);
      drain();
      // Term count zero: coefficients are ignored.
      load_terms(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 16'hFFFF, 3'd0);
      send_arg(32'sh1234_5678);
      drain();
      // All exponents at maximum: each term replaces the one before.
      load_terms(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 16'hFFFF, 3'd4);
      send_arg(32'sh0001_0000);
      send_arg(32'sh0000_F000);
      drain();
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall, input int beats);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      for (int n = 0; n < beats; n++) begin
         if (n % 40 == 0) begin
            drain();
            load_random_terms();
         end
         send_arg(rand_arg());
      end
      drain();
   endtask

   // Hold results off for a long stretch while arguments keep coming; the
   // stretch outlasts two full evaluations so a finished result backs up.
   task automatic test_backpressure;
      send_idle_pct = 0;
      stall_pct = 0;
      load_terms(3 * Q_ONE, -Q_ONE, 32'sh0000_4000, 0, 16'h0321, 3'd3);
      hold_off_cycles = 2500;
      repeat (8) send_arg(rand_arg());
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_arg_x = '0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int k = 0; k < NUM_COEF; k++) coef_q[k] = '0;
      exp_pack_q = '0;
      term_count_q = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_terms();
      test_directed();
      test_random_phase(0, 0, 480);
      test_random_phase(77, 0, 480);
      test_random_phase(0, 77, 480);
      test_random_phase(37, 37, 480);
      test_backpressure();

      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("** sparse_polynomial_value_slope_core: PASSED **");
      else
         $display("** sparse_polynomial_value_slope_core: FAILED **");
      $finish;
   end

endmodule

[filelist.f]
rtl/spvs_pkg.sv
rtl/spvs_mul.sv
rtl/sparse_polynomial_value_slope_core.sv
test/tb_sparse_polynomial_value_slope_core.sv
